>>> sv/nsr_pkg.sv
// Package with the shared widths, controller states and control bundles of the square root unit.
package nsr_pkg;

  localparam int unsigned MAX_ITERATIONS = 32;
  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned TOL_BITS       = 16;

  localparam int unsigned XW    = 32;
  localparam int unsigned YW    = XW - 1;
  localparam int unsigned SQW   = 2 * YW - FRAC_BITS;
  localparam int unsigned DVDW  = SQW + FRAC_BITS;
  localparam int unsigned DW    = YW + 1;
  localparam int unsigned TFW   = 16;
  localparam int unsigned TOLW  = XW - 1;
  localparam int unsigned ROOTW = 24;
  localparam int unsigned IW    = $clog2(MAX_ITERATIONS + 1);
  localparam int unsigned CW    = $clog2(DVDW);

  localparam logic [TFW-1:0]   TF_RESET = TFW'(66);
  localparam logic [YW-1:0]    Y_MAX    = {YW{1'b1}};
  localparam logic [ROOTW-1:0] ROOT_MAX = {ROOTW{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TOP,
    ST_MAG,
    ST_DSETUP,
    ST_DIV,
    ST_UPD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic zero;
    logic init;
    logic square;
    logic mag;
    logic div_init;
    logic div_step;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic nonpos;
    logic y_zero;
    logic le_tol;
  } status_t;

endpackage

>>> sv/nsr_ctrl.sv
// Controller state machine that sequences the Newton steps and the serial division.
module nsr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  nsr_pkg::status_t status_i,
  output nsr_pkg::cmd_t    cmd_o,
  output logic           busy,
  output logic           result_valid_o
);
  import nsr_pkg::*;

  state_e         state_q, state_d;
  logic [IW-1:0]  iter_q, iter_d;
  logic [CW-1:0]  cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iter_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = status_i.nonpos ? ST_DONE : ST_TOP;
      end
      ST_TOP: begin
        if (status_i.y_zero || iter_q == IW'(MAX_ITERATIONS)) state_d = ST_DONE;
        else state_d = ST_MAG;
      end
      ST_MAG:    state_d = ST_DSETUP;
      ST_DSETUP: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == CW'(DVDW - 1)) state_d = ST_UPD;
      end
      ST_UPD: begin
        state_d = status_i.le_tol ? ST_DONE : ST_TOP;
      end
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    iter_d         = iter_q;
    cnt_d          = cnt_q;
    busy           = (state_q != ST_IDLE);
    result_valid_o = (state_q == ST_DONE);
    unique case (state_q)
      ST_IDLE:   cmd_o.load = start;
      ST_CHECK: begin
        cmd_o.zero = status_i.nonpos;
        cmd_o.init = !status_i.nonpos;
        iter_d     = '0;
      end
      ST_TOP:    cmd_o.square = 1'b1;
      ST_MAG:    cmd_o.mag = 1'b1;
      ST_DSETUP: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CW'(1);
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        iter_d       = iter_q + IW'(1);
      end
      ST_DONE:   cmd_o = '0;
      default:   cmd_o = '0;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (iter_q < IW'(MAX_ITERATIONS)))
    else $error("division started beyond the step cap");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> $past(state_q == ST_DIV))
    else $error("update without a finished division");

endmodule

>>> sv/nsr_dpath.sv
// Datapath with the estimate, tolerance, squaring, serial divider and result logic.
module nsr_dpath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  nsr_pkg::cmd_t             cmd_i,
  output nsr_pkg::status_t          status_o,
  input  logic [nsr_pkg::XW-1:0]    x_value_i,
  input  logic                      cfg_valid_i,
  input  logic [nsr_pkg::TFW-1:0]   cfg_data_i,
  output logic [nsr_pkg::ROOTW-1:0] root_o,
  output logic                      converged_o
);
  import nsr_pkg::*;

  logic [TFW-1:0]   tf_q;
  logic [XW-1:0]    x_q;
  logic [YW-1:0]    y_q, y_d;
  logic [TOLW-1:0]  tol_q;
  logic [SQW-1:0]   sq_q, mag_q;
  logic             neg_q, le_tol_q, conv_q, nonpos_q;
  logic [DW-1:0]    rem_q, div_q;
  logic [DVDW-1:0]  dvd_q, quo_q;

  logic [YW+TFW-1:0] tol_prod;
  logic [2*YW-1:0]   sq_prod;
  logic [SQW-1:0]    x_ext;
  logic [DW:0]       trial, trial_sub;
  logic              qbit;
  logic [DVDW:0]     sum;

  assign tol_prod  = (YW+TFW)'(x_q[YW-1:0]) * (YW+TFW)'(tf_q);
  assign sq_prod   = (2*YW)'(y_q) * (2*YW)'(y_q);
  assign x_ext     = SQW'(x_q[YW-1:0]);
  assign trial     = {rem_q, dvd_q[DVDW-1]};
  assign trial_sub = trial - {1'b0, div_q};
  assign qbit      = (trial >= {1'b0, div_q});
  assign sum       = (DVDW+1)'(quo_q) + (DVDW+1)'(y_q);

  always_comb begin
    if (neg_q) begin
      y_d = (sum > (DVDW+1)'(Y_MAX)) ? Y_MAX : sum[YW-1:0];
    end else begin
      y_d = (quo_q >= DVDW'(y_q)) ? '0 : (y_q - quo_q[YW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tf_q <= TF_RESET;
    end else if (cfg_valid_i) begin
      tf_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) x_q <= x_value_i;
    if (cmd_i.zero) begin
      y_q      <= '0;
      conv_q   <= 1'b1;
      nonpos_q <= 1'b1;
    end
    if (cmd_i.init) begin
      y_q      <= x_q[YW:1];
      tol_q    <= tol_prod[TOL_BITS +: TOLW];
      conv_q   <= 1'b0;
      nonpos_q <= 1'b0;
    end
    if (cmd_i.square) sq_q <= sq_prod[FRAC_BITS +: SQW];
    if (cmd_i.mag) begin
      neg_q <= (sq_q < x_ext);
      mag_q <= (sq_q >= x_ext) ? (sq_q - x_ext) : (x_ext - sq_q);
    end
    if (cmd_i.div_init) begin
      le_tol_q <= (mag_q <= SQW'(tol_q));
      rem_q    <= '0;
      div_q    <= {y_q, 1'b0};
      dvd_q    <= {mag_q, {FRAC_BITS{1'b0}}};
      quo_q    <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= qbit ? trial_sub[DW-1:0] : trial[DW-1:0];
      dvd_q <= {dvd_q[DVDW-2:0], 1'b0};
      quo_q <= {quo_q[DVDW-2:0], qbit};
    end
    if (cmd_i.update) begin
      y_q    <= y_d;
      conv_q <= le_tol_q;
    end
  end

  assign status_o.nonpos = (x_q == '0) || x_q[XW-1];
  assign status_o.y_zero = (y_q == '0);
  assign status_o.le_tol = le_tol_q;

  assign root_o      = (y_q > YW'(ROOT_MAX)) ? ROOT_MAX : y_q[ROOTW-1:0];
  assign converged_o = conv_q && (nonpos_q || (y_q != '0));

endmodule

>>> sv/newton_square_root_unit.sv
// Top level of the fixed-point Newton-Raphson square root unit.
// A radicand item is taken on x_value_i at a clock edge where start is high and busy
// is low. busy stays high until the result has been shown. The result appears on
// root_o and converged_o for exactly one cycle, flagged by result_valid_o, and the
// receiver cannot stall it. A nonpositive radicand returns zero without any Newton
// step. Otherwise each Newton step squares the estimate, forms the difference,
// sets up the one bit per cycle divider, runs it over the 62 dividend bits and
// updates the estimate. An item stops when it meets its tolerance, on the step cap
// or on a zero estimate; a new item is taken the cycle after the result.
// The tolerance register is to be written through cfg_valid_i and cfg_data_i only
// while the unit is idle, which it does not enforce; cfg_ready_o is always high. Reset
// returns the controller to idle and sets the tolerance to its default 66, about 0.001.
module newton_square_root_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [nsr_pkg::XW-1:0]    x_value_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [nsr_pkg::TFW-1:0]   cfg_data_i,
  output logic                      result_valid_o,
  output logic [nsr_pkg::ROOTW-1:0] root_o,
  output logic                      converged_o
);
  import nsr_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  nsr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  nsr_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .x_value_i   (x_value_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .root_o      (root_o),
    .converged_o (converged_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("item taken but unit not busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result shown while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !busy)
    else $error("unit not idle after the result");

endmodule
